// ===== rtl/tile_grid_rect_blocked_check_assert.svh =====
// Assertion macros for the tile grid rectangle blocked check.
`ifndef TILE_GRID_RECT_BLOCKED_CHECK_ASSERT_SVH
`define TILE_GRID_RECT_BLOCKED_CHECK_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: when ante holds, cons holds too.
`define TGRBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tgrbc same-cycle check failed");
// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define TGRBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tgrbc next-cycle check failed");
`else
`define TGRBC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TGRBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/tgrbc_pkg.sv =====
// Types and constants shared by the tile grid rectangle blocked check.
package tgrbc_pkg;

   // Tile index width: map_cols and map_rows are 7-bit registers.
   localparam int IDX_W = 7;
   // Pixel coordinate magnitude width (non-negative part of a 16-bit value).
   localparam int PIX_W = 15;
   // Tile size width.
   localparam int TILE_W = 8;
   // Restoring divider: one quotient bit per step.
   localparam int DIV_STEPS = PIX_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Request modes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_MAP_COLS    = 2'd0,
      REG_MAP_ROWS    = 2'd1,
      REG_TILE_WIDTH  = 2'd2,
      REG_TILE_HEIGHT = 2'd3
   } cfg_reg_type;

   // Divider operand select, in the order the sequencer runs them.
   typedef enum logic [1:0] {
      DIV_COL_FIRST = 2'd0,
      DIV_COL_LAST  = 2'd1,
      DIV_ROW_FIRST = 2'd2,
      DIV_ROW_LAST  = 2'd3
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX,
      ST_CHECK,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_SCAN_SETUP,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/tile_grid_rect_blocked_check.sv =====
// Top level: wall bitmap with a sequenced rectangle collision query.
//
// Tile grid rectangle blocked check. The block holds one wall bit per tile of
// a grid of up to MAX_ROWS x MAX_COLS tiles in a two-port bit memory. A
// request beat with mode 0 writes one tile's wall bit (rows or columns outside
// the storage are dropped) and produces no response. A request beat with
// mode 1 carries a pixel rectangle and produces exactly one response beat with
// the blocked flag: set when the rectangle starts at a negative coordinate or
// its end (start + size) reaches the map's pixel edge, else the OR of the wall
// bits of all tiles it covers. map_cols / map_rows above the storage size act
// as the storage size; a zero tile size or map size blocks every query.
// Timing: after reset the block runs a clearing sweep over all MAX_ROWS * MAX_COLS
// tiles with req_stall high (configuration writes are still taken). A wall
// write leaves the block idle. A query holds req_stall for its whole run:
// it forms the map's pixel extent, checks bounds, then runs four tile-index
// divisions (first and last column, first and last row) on one shared
// restoring divider, then one memory read per covered tile, plus setup, drain
// and result states; a query rejected by the bounds check goes straight to
// the result. The shared divider and the single memory read port set the
// length of a query's run. The result sits in an output register, so a new
// request beat is taken while a response beat still waits on rsp_stall.
// Registers live at byte addresses 0 (map_cols), 4 (map_rows), 8
// (tile_width) and 12 (tile_height).
module tile_grid_rect_blocked_check
   import tgrbc_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic [5:0]               req_tile_row,
   input  logic [5:0]               req_tile_col,
   input  logic                     req_wall_bit,
   input  logic signed [15:0]       req_rect_x,
   input  logic signed [15:0]       req_rect_y,
   input  logic [14:0]              req_rect_w,
   input  logic [14:0]              req_rect_h,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_blocked,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type                 state_ff, state_in;

   logic [IDX_W-1:0]          map_cols_ff, map_rows_ff;
   logic [TILE_W-1:0]         tile_width_ff, tile_height_ff;

   logic [15:0]               x_ff, y_ff;
   logic [PIX_W-1:0]          w_ff, h_ff;

   logic [PIX_W-1:0]          pix_w_ff, pix_w_in;
   logic [PIX_W-1:0]          pix_h_ff, pix_h_in;
   logic [PIX_W-1:0]          last_x_ff, last_x_in;
   logic [PIX_W-1:0]          last_y_ff, last_y_in;

   div_sel_type               div_sel_ff, div_sel_in;
   logic [DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic [TILE_W-1:0]         div_rem_ff, div_rem_in;
   logic [PIX_W-1:0]          div_quo_ff, div_quo_in;

   logic [IDX_W-1:0]          c0_ff, c0_in, c1_ff, c1_in;
   logic [IDX_W-1:0]          r0_ff, r0_in, r1_ff, r1_in;
   logic [IDX_W-1:0]          c_ff, c_in, r_ff, r_in;
   logic [AW-1:0]             row_base_ff, row_base_in;
   logic [AW-1:0]             clr_addr_ff, clr_addr_in;

   logic                      hit_ff, hit_in;
   logic                      res_ff, res_in;
   logic                      rd_vld_ff;
   logic                      mem_q_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_blocked_ff, rsp_blocked_in;

   // Wall bitmap, one bit per tile, row-major with MAX_COLS per row.
   logic                      wall_mem [DEPTH];

   // ---------------------------------------------------------------------
   // Handshakes and configuration port
   // ---------------------------------------------------------------------
   logic req_accept;
   logic cfg_we;
   logic rsp_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign pready     = 1'b1;
   assign cfg_we     = psel && penable && pwrite && pready;
   // Output register can take a new beat when empty or being drained now.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_blocked = rsp_blocked_ff;

   always_comb begin
      case (cfg_reg_type'(paddr[3:2]))
         REG_MAP_COLS:    prdata = 32'(map_cols_ff);
         REG_MAP_ROWS:    prdata = 32'(map_rows_ff);
         REG_TILE_WIDTH:  prdata = 32'(tile_width_ff);
         REG_TILE_HEIGHT: prdata = 32'(tile_height_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------------
   // Map size clamped to storage.
   logic [IDX_W-1:0] cols_eff, rows_eff;
   assign cols_eff = (32'(map_cols_ff) > MAX_COLS) ? IDX_W'(MAX_COLS) : map_cols_ff;
   assign rows_eff = (32'(map_rows_ff) > MAX_ROWS) ? IDX_W'(MAX_ROWS) : map_rows_ff;

   // Rectangle ends; x and y are non-negative whenever these matter.
   logic [PIX_W:0] sum_x, sum_y;
   logic           out_of_map;
   assign sum_x = {1'b0, x_ff[PIX_W-1:0]} + {1'b0, w_ff};
   assign sum_y = {1'b0, y_ff[PIX_W-1:0]} + {1'b0, h_ff};
   assign out_of_map = x_ff[15] || y_ff[15] ||
                       (sum_x >= {1'b0, pix_w_ff}) || (sum_y >= {1'b0, pix_h_ff});

   // Shared restoring divider: one quotient bit per cycle.
   logic [TILE_W-1:0] div_divisor;
   logic [PIX_W-1:0]  div_operand;
   logic [TILE_W:0]   div_shift;
   logic              div_ge;
   logic [TILE_W-1:0] div_rem_step;
   logic [PIX_W-1:0]  div_quo_step;

   always_comb begin
      case (div_sel_ff)
         DIV_COL_FIRST: div_operand = x_ff[PIX_W-1:0];
         DIV_COL_LAST:  div_operand = last_x_ff;
         DIV_ROW_FIRST: div_operand = y_ff[PIX_W-1:0];
         DIV_ROW_LAST:  div_operand = last_y_ff;
         default:       div_operand = '0;
      endcase
   end

   assign div_divisor  = div_sel_ff[1] ? tile_height_ff : tile_width_ff;
   assign div_shift    = {div_rem_ff, div_quo_ff[PIX_W-1]};
   assign div_ge       = (div_shift >= {1'b0, div_divisor});
   assign div_rem_step = div_ge ? TILE_W'(div_shift - {1'b0, div_divisor})
                                : div_shift[TILE_W-1:0];
   assign div_quo_step = {div_quo_ff[PIX_W-2:0], div_ge};

   // Memory addressing.
   logic [AW-1:0] scan_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_in_range;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          mem_wdata;

   assign scan_addr   = row_base_ff + AW'(c_ff);
   assign wr_addr     = AW'(32'(req_tile_row) * MAX_COLS + 32'(req_tile_col));
   assign wr_in_range = (32'(req_tile_row) < MAX_ROWS) && (32'(req_tile_col) < MAX_COLS);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = 1'b0;
      end else begin
         mem_we    = req_accept && (req_mode == MODE_WRITE) && wr_in_range;
         mem_waddr = wr_addr;
         mem_wdata = req_wall_bit;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && (req_mode == MODE_QUERY)) begin
               state_in = ST_PIX;
            end
         end
         ST_PIX: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = out_of_map ? ST_RESP : ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = (div_sel_ff == DIV_ROW_LAST) ? ST_SCAN_SETUP : ST_DIV_LOAD;
            end
         end
         ST_SCAN_SETUP: begin
            state_in = ((c1_ff < c0_ff) || (r1_ff < r0_ff)) ? ST_RESP : ST_SCAN;
         end
         ST_SCAN: begin
            if ((c_ff == c1_ff) && (r_ff == r1_ff)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: datapath controls
   // ---------------------------------------------------------------------
   always_comb begin
      pix_w_in       = pix_w_ff;
      pix_h_in       = pix_h_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      div_sel_in     = div_sel_ff;
      div_cnt_in     = div_cnt_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      c0_in          = c0_ff;
      c1_in          = c1_ff;
      r0_in          = r0_ff;
      r1_in          = r1_ff;
      c_in           = c_ff;
      r_in           = r_ff;
      row_base_in    = row_base_ff;
      clr_addr_in    = clr_addr_ff;
      hit_in         = hit_ff || (rd_vld_ff && mem_q_ff);
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_blocked_in = rsp_blocked_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         ST_PIX: begin
            // Zero map or tile size gives a zero extent, which blocks.
            pix_w_in = PIX_W'(cols_eff * tile_width_ff);
            pix_h_in = PIX_W'(rows_eff * tile_height_ff);
         end
         ST_CHECK: begin
            // Last covered pixel; an empty rectangle at zero maps to zero.
            last_x_in  = (sum_x == '0) ? '0 : PIX_W'(sum_x - (PIX_W+1)'(1));
            last_y_in  = (sum_y == '0) ? '0 : PIX_W'(sum_y - (PIX_W+1)'(1));
            res_in     = 1'b1;
            div_sel_in = DIV_COL_FIRST;
         end
         ST_DIV_LOAD: begin
            div_quo_in = div_operand;
            div_rem_in = '0;
            div_cnt_in = '0;
         end
         ST_DIV_STEP: begin
            div_quo_in = div_quo_step;
            div_rem_in = div_rem_step;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               // Tile indices stay below the map size once bounds pass.
               case (div_sel_ff)
                  DIV_COL_FIRST: c0_in = IDX_W'(div_quo_step);
                  DIV_COL_LAST:  c1_in = IDX_W'(div_quo_step);
                  DIV_ROW_FIRST: r0_in = IDX_W'(div_quo_step);
                  DIV_ROW_LAST:  r1_in = IDX_W'(div_quo_step);
                  default:       c0_in = c0_ff;
               endcase
               div_sel_in = div_sel_type'(div_sel_ff + 2'd1);
            end
         end
         ST_SCAN_SETUP: begin
            c_in        = c0_ff;
            r_in        = r0_ff;
            row_base_in = AW'(32'(r0_ff) * MAX_COLS);
            hit_in      = 1'b0;
            res_in      = 1'b0;
         end
         ST_SCAN: begin
            // Walk columns within a row, then advance the row.
            if (c_ff == c1_ff) begin
               c_in        = c0_ff;
               r_in        = r_ff + IDX_W'(1);
               row_base_in = row_base_ff + AW'(MAX_COLS);
            end else begin
               c_in = c_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            res_in = hit_ff || (rd_vld_ff && mem_q_ff);
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_blocked_in = res_ff;
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Register update
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         map_cols_ff    <= IDX_W'(64);
         map_rows_ff    <= IDX_W'(64);
         tile_width_ff  <= TILE_W'(16);
         tile_height_ff <= TILE_W'(16);
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_vld_ff    <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_we) begin
            case (cfg_reg_type'(paddr[3:2]))
               REG_MAP_COLS:    map_cols_ff    <= pwdata[IDX_W-1:0];
               REG_MAP_ROWS:    map_rows_ff    <= pwdata[IDX_W-1:0];
               REG_TILE_WIDTH:  tile_width_ff  <= pwdata[TILE_W-1:0];
               REG_TILE_HEIGHT: tile_height_ff <= pwdata[TILE_W-1:0];
               default:         map_cols_ff    <= map_cols_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_mode == MODE_QUERY)) begin
         x_ff <= req_rect_x;
         y_ff <= req_rect_y;
         w_ff <= req_rect_w;
         h_ff <= req_rect_h;
      end
      pix_w_ff       <= pix_w_in;
      pix_h_ff       <= pix_h_in;
      last_x_ff      <= last_x_in;
      last_y_ff      <= last_y_in;
      div_sel_ff     <= div_sel_in;
      div_cnt_ff     <= div_cnt_in;
      div_rem_ff     <= div_rem_in;
      div_quo_ff     <= div_quo_in;
      c0_ff          <= c0_in;
      c1_ff          <= c1_in;
      r0_ff          <= r0_in;
      r1_ff          <= r1_in;
      c_ff           <= c_in;
      r_ff           <= r_in;
      row_base_ff    <= row_base_in;
      hit_ff         <= hit_in;
      res_ff         <= res_in;
      rsp_blocked_ff <= rsp_blocked_in;
   end

   // Wall bitmap: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wall_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= wall_mem[scan_addr];
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`include "tile_grid_rect_blocked_check_assert.svh"

   // The scan never leaves the rectangle's tile range.
   `TGRBC_ASSERT_IMPL(a_scan_in_range, clock, reset, (state_ff == ST_SCAN), (c_ff >= c0_ff && c_ff <= c1_ff && r_ff >= r0_ff && r_ff <= r1_ff))

   // Divider remainder stays below the divisor during every step.
   `TGRBC_ASSERT_IMPL(a_div_rem_bound, clock, reset, (state_ff == ST_DIV_STEP), (div_rem_ff < div_divisor))

   // The last divider step hands over to the next division or the scan.
   `TGRBC_ASSERT_NEXT(a_div_handover, clock, reset, (state_ff == ST_DIV_STEP && div_cnt_ff == DIV_LAST), (state_ff == ST_DIV_LOAD || state_ff == ST_SCAN_SETUP))

   // A finished query lands in the output register and frees the input.
   `TGRBC_ASSERT_NEXT(a_resp_delivered, clock, reset, (state_ff == ST_RESP && rsp_free), (rsp_valid && state_ff == ST_IDLE))

endmodule

// ===== sim/tb_tile_grid_rect_blocked_check.sv =====
// Self-checking testbench for the tile grid rectangle blocked check: wall writes, rect queries.
module tb_tile_grid_rect_blocked_check
   import tgrbc_pkg::*;
();

   // Storage size of the wall bitmap, passed to the block as well.
   localparam int MAP_MAX = 64;
   // Random beats per configuration phase; eight phases.
   localparam int NUM_PHASES = 8;
   localparam int RAND_PER_PHASE = 160;
   // Long receiver hold-off, in cycles.
   localparam int HOLD_CYCLES = 3000;
   // Watchdog: cycles without any accepted beat. The slowest legal stretch is
   // a full-map scan or the hold-off above.
   localparam int WATCHDOG_LIMIT = 40000;
   // Settle time after the last result before a register write or the end.
   localparam int SETTLE_CYCLES = 16;

   typedef struct {
      bit              mode;
      bit [5:0]        tile_row;
      bit [5:0]        tile_col;
      bit              wall_bit;
      bit signed [15:0] rect_x;
      bit signed [15:0] rect_y;
      bit [14:0]       rect_w;
      bit [14:0]       rect_h;
   } tile_req_type;

   // DUT signals; the inputs are known from time zero.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_mode = 1'b0;
   logic [5:0]          req_tile_row = '0;
   logic [5:0]          req_tile_col = '0;
   logic                req_wall_bit = 1'b0;
   logic signed [15:0]  req_rect_x = '0;
   logic signed [15:0]  req_rect_y = '0;
   logic [14:0]         req_rect_w = '0;
   logic [14:0]         req_rect_h = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_blocked;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [3:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   // Shadow copy of the block's state and registers.
   bit                  wall_map [MAP_MAX][MAP_MAX];
   bit [6:0]            cfg_cols = 7'd64;
   bit [6:0]            cfg_rows = 7'd64;
   bit [7:0]            cfg_tw = 8'd16;
   bit [7:0]            cfg_th = 8'd16;

   // Beats waiting to be driven, and blocked flags waiting to come back.
   tile_req_type        pending_q [$];
   bit                  blocked_flags_q [$];
   tile_req_type        drive_beat;

   int                  send_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   int                  hold_reqs = 0;
   int                  hold_done = 0;
   int                  hold_left = 0;
   int                  err_count = 0;
   int                  quiet_cycles = 0;
   bit                  want_blocked;

   tile_grid_rect_blocked_check #(
      .MAX_ROWS (MAP_MAX),
      .MAX_COLS (MAP_MAX)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_tile_row (req_tile_row),
      .req_tile_col (req_tile_col),
      .req_wall_bit (req_wall_bit),
      .req_rect_x   (req_rect_x),
      .req_rect_y   (req_rect_y),
      .req_rect_w   (req_rect_w),
      .req_rect_h   (req_rect_h),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_blocked  (rsp_blocked),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Map size in tiles as the block sees it: clamp to the storage size.
   function automatic int eff_tiles(int n);
      return (n > MAP_MAX) ? MAP_MAX : n;
   endfunction

   // Blocked flag for one query against the shadow bitmap and registers.
   function automatic bit rect_blocked(tile_req_type it);
      int x, y, w, h, tw, th, pix_w, pix_h, c0, c1, r0, r1;
      bit hit;
      x = it.rect_x;
      y = it.rect_y;
      w = it.rect_w;
      h = it.rect_h;
      tw = cfg_tw;
      th = cfg_th;
      pix_w = eff_tiles(cfg_cols) * tw;
      pix_h = eff_tiles(cfg_rows) * th;
      // Out of bounds, including a zero map or tile size (extent zero).
      hit = (x < 0) || (x + w >= pix_w) || (y < 0) || (y + h >= pix_h);
      if (!hit) begin
         // End tile of an empty rect at start 0 truncates to tile 0.
         c0 = x / tw;
         c1 = (x + w - 1 < 0) ? 0 : (x + w - 1) / tw;
         r0 = y / th;
         r1 = (y + h - 1 < 0) ? 0 : (y + h - 1) / th;
         for (int c = c0; c <= c1; c++) begin
            for (int r = r0; r <= r1; r++) begin
               if (wall_map[r][c]) hit = 1'b1;
            end
         end
      end
      return hit;
   endfunction

   // Advance the shadow state by one accepted request beat.
   function automatic void track_beat(tile_req_type it);
      if (it.mode == MODE_WRITE) begin
         wall_map[it.tile_row][it.tile_col] = it.wall_bit;
      end else begin
         blocked_flags_q.insert(blocked_flags_q.size(), rect_blocked(it));
      end
   endfunction

   // Append one beat to the tail of the driver's queue.
   function automatic void queue_beat(tile_req_type it);
      pending_q.insert(pending_q.size(), it);
   endfunction

   // Every field random; callers override what matters.
   function automatic tile_req_type rand_fields();
      tile_req_type it;
      bit [31:0] a, b, c;
      a = $urandom;
      b = $urandom;
      c = $urandom;
      it.mode = a[0];
      it.tile_row = a[6:1];
      it.tile_col = a[12:7];
      it.wall_bit = a[13];
      it.rect_x = b[15:0];
      it.rect_y = b[31:16];
      it.rect_w = c[14:0];
      it.rect_h = c[29:15];
      return it;
   endfunction

   function automatic tile_req_type mk_write(int row, int col, bit wall);
      tile_req_type it;
      it = rand_fields();
      it.mode = MODE_WRITE;
      it.tile_row = row[5:0];
      it.tile_col = col[5:0];
      it.wall_bit = wall;
      return it;
   endfunction

   function automatic tile_req_type mk_query(int x, int y, int w, int h);
      tile_req_type it;
      it = rand_fields();
      it.mode = MODE_QUERY;
      it.rect_x = x[15:0];
      it.rect_y = y[15:0];
      it.rect_w = w[14:0];
      it.rect_h = h[14:0];
      return it;
   endfunction

   // Start coordinate inside the map, biased to the edges and tile borders.
   function automatic int pick_coord(int pix, int tile, int ntiles);
      case ($urandom_range(9))
         0: return 0;
         1: return pix - 1;
         2: return $urandom_range(ntiles - 1, 0) * tile;
         default: return $urandom_range(pix - 1, 0);
      endcase
   endfunction

   // Size for the room left, with empty rects and both sides of the edge; random sizes may overrun it.
   function automatic int pick_size(int room, int tile);
      int s;
      case ($urandom_range(9))
         0: s = 0;
         1: s = room - 1;
         2: s = room;
         default: s = $urandom_range(2 * tile, 0);
      endcase
      return (s > 32767) ? 32767 : s;
   endfunction

   // Mostly well-formed writes and in-map queries, some raw noise.
   function automatic tile_req_type rand_item();
      int k, cols, rows, pix_w, pix_h, x, y, row, col;
      k = $urandom_range(99);
      cols = eff_tiles(cfg_cols);
      rows = eff_tiles(cfg_rows);
      pix_w = cols * cfg_tw;
      pix_h = rows * cfg_th;
      if (k < 10) return rand_fields();
      if (k < 40) begin
         row = (rows > 0) ? $urandom_range(rows - 1, 0) : $urandom_range(MAP_MAX - 1, 0);
         col = (cols > 0) ? $urandom_range(cols - 1, 0) : $urandom_range(MAP_MAX - 1, 0);
         return mk_write(row, col, $urandom_range(99) < 35);
      end
      if (pix_w == 0 || pix_h == 0) begin
         return mk_query($urandom_range(100), $urandom_range(100),
                         $urandom_range(50), $urandom_range(50));
      end
      x = pick_coord(pix_w, cfg_tw, cols);
      y = pick_coord(pix_h, cfg_th, rows);
      return mk_query(x, y, pick_size(pix_w - x, cfg_tw), pick_size(pix_h - y, cfg_th));
   endfunction

   // One APB write: setup cycle, then access until pready.
   task automatic csr_write(cfg_reg_type idx, int val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_MAP_COLS:    cfg_cols = val[6:0];
         REG_MAP_ROWS:    cfg_rows = val[6:0];
         REG_TILE_WIDTH:  cfg_tw = val[7:0];
         REG_TILE_HEIGHT: cfg_th = val[7:0];
         default:         cfg_cols = cfg_cols;
      endcase
   endtask

   // Hold until every queued beat is in and every blocked flag is back, then
   // let a write still in flight finish.
   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || blocked_flags_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: track the beat taken at this edge, then offer the next
   // one or idle. A stalled beat holds its payload.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) track_beat(drive_beat);
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_beat = pending_q.pop_front();
               req_valid <= 1'b1;
               req_mode <= drive_beat.mode;
               req_tile_row <= drive_beat.tile_row;
               req_tile_col <= drive_beat.tile_col;
               req_wall_bit <= drive_beat.wall_bit;
               req_rect_x <= drive_beat.rect_x;
               req_rect_y <= drive_beat.rect_y;
               req_rect_w <= drive_beat.rect_w;
               req_rect_h <= drive_beat.rect_h;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response stall: a requested long hold-off first, else random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_done < hold_reqs) begin
         hold_done = hold_done + 1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Response checker and watchdog.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blocked_flags_q.size() == 0) begin
            $error("blocked: expected none, actual %0b", rsp_blocked);
            err_count++;
         end else begin
            want_blocked = blocked_flags_q.pop_front();
            if (rsp_blocked !== want_blocked) begin
               $error("blocked: expected %0b, actual %0b", want_blocked, rsp_blocked);
               err_count++;
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tile_grid_rect_blocked_check regression: fail");
         $finish;
      end
   end

   initial begin
      int cv [4];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // Idle mix rotates: none, sender, receiver, both lightly.
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 57; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 57; end
            default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         // Register settings: defaults, minimum, oversize map with largest
         // tiles, zero sizes, odd sizes, one-pixel tiles, then random ones.
         case (ph)
            0: cv = '{64, 64, 16, 16};
            1: cv = '{1, 1, 1, 1};
            2: cv = '{127, 127, 255, 255};
            3: cv = '{0, 5, 8, 0};
            4: cv = '{10, 7, 3, 5};
            5: cv = '{64, 64, 1, 1};
            6: cv = '{$urandom_range(64, 1), $urandom_range(64, 1),
                      $urandom_range(32, 1), $urandom_range(32, 1)};
            default: cv = '{64, $urandom_range(64, 1),
                            $urandom_range(255, 1), $urandom_range(8, 1)};
         endcase
         for (int k = 0; k < 4; k++) csr_write(cfg_reg_type'(k), cv[k]);
         @(negedge clock);
         if (ph == 0) begin
            // Directed beats on the default 64x64 map of 16-pixel tiles.
            queue_beat(mk_write(0, 0, 1'b1));
            queue_beat(mk_write(63, 63, 1'b1));
            queue_beat(mk_write(10, 20, 1'b1));
            // Empty rect at the origin still reads tile 0,0.
            queue_beat(mk_query(0, 0, 0, 0));
            // Empty rect on a tile border scans nothing.
            queue_beat(mk_query(16, 16, 0, 0));
            // Negative starts, largest start and largest sizes.
            queue_beat(mk_query(-1, 5, 2, 2));
            queue_beat(mk_query(5, -32768, 2, 2));
            queue_beat(mk_query(32767, 5, 0, 0));
            queue_beat(mk_query(0, 0, 32767, 32767));
            // Right and bottom edge: one pixel short, then touching.
            queue_beat(mk_query(1008, 1008, 15, 15));
            queue_beat(mk_query(1008, 1008, 16, 15));
            queue_beat(mk_query(1008, 1008, 15, 16));
            queue_beat(mk_query(1000, 0, 23, 10));
            // Around the wall at row 10, col 20.
            queue_beat(mk_query(320, 160, 1, 1));
            queue_beat(mk_query(304, 144, 16, 16));
            queue_beat(mk_query(304, 144, 17, 17));
            queue_beat(mk_write(0, 0, 1'b0));
            queue_beat(mk_query(0, 0, 0, 0));
            queue_beat(mk_write(63, 63, 1'b0));
            queue_beat(mk_query(0, 0, 1023, 1023));
            queue_beat(mk_write(10, 20, 1'b0));
            queue_beat(mk_query(0, 0, 1023, 1023));
            queue_beat(mk_query(1023, 1023, 0, 0));
            queue_beat(mk_query(5, 1024, 0, 0));
         end
         // Long response hold-off while the sender keeps offering beats.
         if (ph == 4) hold_reqs++;
         repeat (RAND_PER_PHASE) queue_beat(rand_item());
         wait_drained();
      end
      repeat (64) @(negedge clock);
      if (err_count == 0 && blocked_flags_q.size() == 0) begin
         $display("tile_grid_rect_blocked_check regression: pass");
      end else begin
         $display("tile_grid_rect_blocked_check regression: fail");
      end
      $finish;
   end

endmodule

// ===== tile_grid_rect_blocked_check.f =====
+incdir+rtl
rtl/tgrbc_pkg.sv
rtl/tile_grid_rect_blocked_check.sv
sim/tb_tile_grid_rect_blocked_check.sv
